// ===== hdl/configurable_crc_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// configurable_crc_engine_core_defines.svh
// Assertion macros shared by the checker of the crc engine
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_CORE_DEFINES_SVH

// property checked only while out of reset
`define CCE_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// cce_pkg
// Types and constants of the configurable crc engine
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int CRC_W = 32;

    // crc width codes
    typedef enum logic [1:0] {
        WIDTH_8    = 2'd0,
        WIDTH_16   = 2'd1,
        WIDTH_32   = 2'd2,
        WIDTH_NONE = 2'd3
    } width_mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_WIDTH_MODE     = 3'd0,
        REG_REFLECT_INPUT  = 3'd1,
        REG_REFLECT_OUTPUT = 3'd2,
        REG_POLYNOMIAL     = 3'd3,
        REG_INITIAL_VALUE  = 3'd4,
        REG_FINAL_XOR      = 3'd5
    } reg_index_t;

    // reset values of the configuration
    localparam width_mode_t       RST_WIDTH_MODE     = WIDTH_32;
    localparam logic              RST_REFLECT_INPUT  = 1'b1;
    localparam logic              RST_REFLECT_OUTPUT = 1'b1;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL     = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]  RST_INITIAL_VALUE  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  RST_FINAL_XOR      = 32'hFFFF_FFFF;

    // configuration seen by the datapath
    typedef struct packed {
        width_mode_t       width_mode;
        logic              reflect_input;
        logic              reflect_output;
        logic [CRC_W-1:0]  polynomial;
        logic [CRC_W-1:0]  initial_value;
        logic [CRC_W-1:0]  final_xor;
    } cfg_t;

    // classified item as held in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       load;
        logic       absorb;
        logic       emit;
    } item_t;

endpackage

// ===== hdl/configurable_crc_engine_core.sv =====
// ----------------------------------------------------------------------------
// configurable_crc_engine_core
// Byte-serial msb-first crc engine for 8, 16 or 32 bit crcs
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the in channel (in_valid/in_ready) with data_byte,
//   byte_present, first_item and last_item. An item with last_item set
//   produces one crc_value on the out channel (out_valid/out_ready).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   An accepted last item waits in the input queue; the crc stage loads the
//   output register, raising out_valid, at the edge that takes it from the
//   queue. One item per clock is sustained while no result waits on
//   out_ready; eight unrolled shift and xor steps absorb a whole byte.
// Stalls:
//   When out_ready is low the result is held; the crc stage keeps taking
//   items that carry no result, and the input queue fills before in_ready
//   drops.
// Reset:
//   Configuration returns to crc-32 defaults, the crc register to all ones,
//   queue and output are emptied.
// ----------------------------------------------------------------------------
module configurable_crc_engine_core
    import cce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CRC_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              first_item,
    input  logic              last_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CRC_W-1:0]  crc_value
);

    cfg_t   cfg_reg, cfg_next;
    logic   q_valid;
    item_t  q_item;
    logic   q_pop;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WIDTH_MODE:     cfg_next.width_mode     = width_mode_t'(cfg_data[1:0]);
                REG_REFLECT_INPUT:  cfg_next.reflect_input  = cfg_data[0];
                REG_REFLECT_OUTPUT: cfg_next.reflect_output = cfg_data[0];
                REG_POLYNOMIAL:     cfg_next.polynomial     = cfg_data;
                REG_INITIAL_VALUE:  cfg_next.initial_value  = cfg_data;
                REG_FINAL_XOR:      cfg_next.final_xor      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_mode     <= RST_WIDTH_MODE;
            cfg_reg.reflect_input  <= RST_REFLECT_INPUT;
            cfg_reg.reflect_output <= RST_REFLECT_OUTPUT;
            cfg_reg.polynomial     <= RST_POLYNOMIAL;
            cfg_reg.initial_value  <= RST_INITIAL_VALUE;
            cfg_reg.final_xor      <= RST_FINAL_XOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input side with item queue
    cce_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .first_item   (first_item),
        .last_item    (last_item),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // crc stage and result register
    cce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value)
    );

endmodule

// ===== hdl/cce_front.sv =====
// ----------------------------------------------------------------------------
// cce_front
// Input side: accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module cce_front
    import cce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        first_item,
    input  logic        last_item,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              item_mem [QUEUE_DEPTH];
    item_t              item_in;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;

    // classify the incoming item
    always_comb
    begin
        item_in.data_byte = data_byte;
        item_in.load      = first_item;
        item_in.absorb    = byte_present;
        item_in.emit      = last_item;
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = item_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== hdl/cce_back.sv =====
// ----------------------------------------------------------------------------
// cce_back
// Execution side: byte-wide crc update, finishing and result register
// ----------------------------------------------------------------------------
module cce_back
    import cce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CRC_W-1:0]  crc_value
);

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [CRC_W-1:0]  out_data_reg, out_data_next;
    logic [CRC_W-1:0]  mask;
    logic [CRC_W-1:0]  poly;
    logic [7:0]        byte_in;
    logic [CRC_W-1:0]  crc_work;
    logic [CRC_W-1:0]  crc_rev;
    logic [CRC_W-1:0]  crc_fin;
    logic [CRC_W-1:0]  result;
    logic              top_bit;

    // width mask and polynomial
    always_comb
    begin
        unique case (cfg.width_mode)
            WIDTH_8:  mask = 32'h0000_00FF;
            WIDTH_16: mask = 32'h0000_FFFF;
            default:  mask = 32'hFFFF_FFFF;
        endcase
        poly = cfg.polynomial & mask;
    end

    // load, absorb one byte with eight shift steps
    always_comb
    begin
        byte_in  = cfg.reflect_input ? {<<{q_item.data_byte}} : q_item.data_byte;
        crc_work = (q_item.load ? cfg.initial_value : crc_reg) & mask;
        top_bit  = 1'b0;
        if (q_item.absorb)
        begin
            unique case (cfg.width_mode)
                WIDTH_8:  crc_work = crc_work ^ {24'd0, byte_in};
                WIDTH_16: crc_work = crc_work ^ {16'd0, byte_in, 8'd0};
                default:  crc_work = crc_work ^ {byte_in, 24'd0};
            endcase
            for (int i = 0; i < 8; i++)
            begin
                unique case (cfg.width_mode)
                    WIDTH_8:  top_bit = crc_work[7];
                    WIDTH_16: top_bit = crc_work[15];
                    default:  top_bit = crc_work[31];
                endcase
                if (top_bit)
                begin
                    crc_work = ((crc_work << 1) ^ poly) & mask;
                end
                else
                begin
                    crc_work = (crc_work << 1) & mask;
                end
            end
        end
    end

    // output reflection and final xor
    always_comb
    begin
        crc_rev = {<<{crc_work}};
        if (cfg.reflect_output)
        begin
            unique case (cfg.width_mode)
                WIDTH_8:  crc_fin = {24'd0, crc_rev[31:24]};
                WIDTH_16: crc_fin = {16'd0, crc_rev[31:16]};
                default:  crc_fin = crc_rev;
            endcase
        end
        else
        begin
            crc_fin = crc_work;
        end
        result = (cfg.width_mode == WIDTH_NONE) ? '0 : ((crc_fin ^ cfg.final_xor) & mask);
    end

    // take an item unless it has a result and the output slot is still full
    assign q_pop = q_valid && (!q_item.emit || !out_valid_reg || out_ready);

    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            crc_next = q_item.emit ? cfg.initial_value : crc_work;
            if (q_item.emit)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= RST_INITIAL_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_data_reg;

endmodule

// ===== hdl/cce_checker.sv =====
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks of the crc engine, bound to the top level
// ----------------------------------------------------------------------------
`include "configurable_crc_engine_core_defines.svh"

module cce_checker
    import cce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CRC_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              last_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CRC_W-1:0]  crc_value
);

    logic [7:0]   pending_reg, pending_next;
    width_mode_t  mode_reg;
    logic         last_in;
    logic         res_out;
    logic         stalled;
    logic         width_ok;

    assign last_in = in_valid && in_ready && last_item;
    assign res_out = out_valid && out_ready;
    assign stalled = out_valid && !out_ready;

    // results owed for accepted last items
    always_comb
    begin
        case ({last_in, res_out})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    // upper crc bits must be clear for the narrow widths, all bits for the no-crc code
    always_comb
    begin
        unique case (mode_reg)
            WIDTH_8:  width_ok = (crc_value[31:8] == '0);
            WIDTH_16: width_ok = (crc_value[31:16] == '0);
            WIDTH_32: width_ok = 1'b1;
            default:  width_ok = (crc_value == '0);
        endcase
    end

    // owed result count, and width mode as written on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            mode_reg    <= RST_WIDTH_MODE;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we && (reg_index_t'(cfg_index) == REG_WIDTH_MODE))
            begin
                mode_reg <= width_mode_t'(cfg_data[1:0]);
            end
        end
    end

    `CCE_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_valid, "result valid during reset")
    `CCE_ASSERT_ON(a_result_held, stalled |=> out_valid && $stable(crc_value), "result changed")
    `CCE_ASSERT_ON(a_result_owed, res_out |-> (pending_reg != '0), "result without a last item")
    `CCE_ASSERT_ON(a_result_width, out_valid |-> width_ok, "crc wider than mode")

endmodule

bind configurable_crc_engine_core cce_checker u_cce_checker (.*);

// ===== verif/configurable_crc_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// configurable_crc_engine_core_test
// Self-checking bench for the byte-serial crc engine: a software crc of the
// same widths, reflections and final xor predicts every emitted crc_value,
// and each value that leaves the block is checked against the oldest
// expectation. Directed items hit empty messages, load-only items, missing
// first flags and every width code, then random messages run under random
// configurations with random idling on both channels.
// ----------------------------------------------------------------------------
module configurable_crc_engine_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    // software crc engine plus the store of crcs still to come out
    class crc_scoreboard;
        width_mode_t      mode;
        logic             rev_in;
        logic             rev_out;
        logic [CRC_W-1:0] poly_reg;
        logic [CRC_W-1:0] init_reg;
        logic [CRC_W-1:0] xor_reg;
        logic [CRC_W-1:0] crc_reg;
        logic [CRC_W-1:0] crc_expected[$];
        int               errors;

        function new();
            mode     = RST_WIDTH_MODE;
            rev_in   = RST_REFLECT_INPUT;
            rev_out  = RST_REFLECT_OUTPUT;
            poly_reg = RST_POLYNOMIAL;
            init_reg = RST_INITIAL_VALUE;
            xor_reg  = RST_FINAL_XOR;
            crc_reg  = RST_INITIAL_VALUE;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return crc_expected.size();
        endfunction

        function logic [CRC_W-1:0] mirror_bits(logic [CRC_W-1:0] v, int unsigned n);
            logic [CRC_W-1:0] r;
            r = '0;
            for (int i = 0; i < n; i++)
                r = (r << 1) | CRC_W'(v[i]);
            return r;
        endfunction

        // register write as the block sees it; unknown indexes do nothing
        function void write_reg(logic [2:0] idx, logic [CRC_W-1:0] v);
            case (idx)
                REG_WIDTH_MODE:     mode     = width_mode_t'(v[1:0]);
                REG_REFLECT_INPUT:  rev_in   = v[0];
                REG_REFLECT_OUTPUT: rev_out  = v[0];
                REG_POLYNOMIAL:     poly_reg = v;
                REG_INITIAL_VALUE:  init_reg = v;
                REG_FINAL_XOR:      xor_reg  = v;
                default: ;
            endcase
        endfunction

        // load, absorb, emit for one accepted item
        function void note_item(logic [7:0] b, logic present, logic first, logic last);
            int unsigned      bits;
            logic [CRC_W-1:0] mask;
            logic [CRC_W-1:0] top;
            logic [CRC_W-1:0] poly;
            logic [CRC_W-1:0] crc;
            logic [7:0]       bb;
            case (mode)
                WIDTH_8:  bits = 8;
                WIDTH_16: bits = 16;
                default:  bits = 32;
            endcase
            mask = (bits >= 32) ? '1 : ((CRC_W'(1) << bits) - 1);
            top  = CRC_W'(1) << (bits - 1);
            poly = poly_reg & mask;
            if (first)
                crc_reg = init_reg;
            crc = crc_reg & mask;
            if (present)
            begin
                bb = rev_in ? 8'(mirror_bits(CRC_W'(b), 8)) : b;
                crc ^= CRC_W'(bb) << (bits - 8);
                for (int i = 0; i < 8; i++)
                begin
                    if ((crc & top) != 0)
                        crc = ((crc << 1) ^ poly) & mask;
                    else
                        crc = (crc << 1) & mask;
                end
            end
            crc_reg = crc;
            if (!last)
                return;
            if (rev_out)
                crc = mirror_bits(crc, bits);
            crc = (crc ^ xor_reg) & mask;
            if (mode == WIDTH_NONE)
                crc = '0;
            crc_expected.push_back(crc);
            crc_reg = init_reg;
        endfunction

        task check_result(logic [CRC_W-1:0] got);
            logic [CRC_W-1:0] want;
            if (crc_expected.size() == 0)
            begin
                report($sformatf("crc_value %h with nothing expected", got));
                return;
            end
            want = crc_expected.pop_front();
            if (got !== want)
                report($sformatf("crc_value %h, expected %h", got, want));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CRC_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte = '0;
    logic             byte_present = 1'b0;
    logic             first_item = 1'b0;
    logic             last_item = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CRC_W-1:0] crc_value;

    crc_scoreboard sb = new();
    int            items_sent = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;

    configurable_crc_engine_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .first_item   (first_item),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crc_value    (crc_value)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("configurable_crc_engine_core_test: done, errors");
            $finish;
        end
    end

    // result side: check accepted crcs, stall now and then
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(crc_value);
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // one item, valid left high after acceptance
    task send_item(logic [7:0] b, logic present, logic first, logic last);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        first_item   <= first;
        last_item    <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(b, present, first, last);
        items_sent++;
    endtask

    // stop sending and let every crc come out before touching registers
    task drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write, enable left high for a following write
    task write_reg(logic [2:0] idx, logic [CRC_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task configure(width_mode_t wm, logic ri, logic ro, logic [CRC_W-1:0] poly,
                   logic [CRC_W-1:0] init, logic [CRC_W-1:0] fx);
        write_reg(REG_WIDTH_MODE, ($urandom & 32'hFFFF_FFFC) | CRC_W'(wm));
        write_reg(REG_REFLECT_INPUT, ($urandom & 32'hFFFF_FFFE) | CRC_W'(ri));
        write_reg(REG_REFLECT_OUTPUT, ($urandom & 32'hFFFF_FFFE) | CRC_W'(ro));
        write_reg(REG_POLYNOMIAL, poly);
        write_reg(REG_INITIAL_VALUE, init);
        write_reg(REG_FINAL_XOR, fx);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // well-known or extreme words most of the time, random otherwise
    function logic [CRC_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h04C1_1DB7;
            3: return 32'h0000_8005;
            4: return 32'h0000_1021;
            default: return $urandom;
        endcase
    endfunction

    // a message of len bytes; len 0 is an empty finish
    task send_message(int len, bit with_first, bit with_last);
        logic f;
        f = with_first;
        if (len == 0)
        begin
            send_item(8'($urandom), 1'b0, f, with_last);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, f, with_last && (i == len - 1));
            f = 1'b0;
        end
    endtask

    initial
    begin
        int          phase_no;
        int          phase_end;
        int          len;
        width_mode_t wm;
        logic [7:0]  check_str[9];

        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: empty message, check string, extreme bytes
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        for (int i = 0; i < 9; i++)
            send_item(check_str[i], 1'b1, i == 0, i == 8);
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        // load-only item, then a message with no first flag
        send_item(8'h5A, 1'b0, 1'b1, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0, 1'b1);
        send_item(8'h3C, 1'b1, 1'b0, 1'b1);
        // finish on the register as it stands
        send_item(8'hFF, 1'b0, 1'b0, 1'b1);
        drain();

        // 8-bit crc, no reflection, plus writes to indexes past the list
        configure(WIDTH_8, 1'b0, 1'b0, 32'h0000_0007, 32'h0000_0000, 32'h0000_0000);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0000);
        cfg_we <= 1'b0;
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        drain();

        // 16-bit crc, then a width change in mid-message
        configure(WIDTH_16, 1'b0, 1'b0, 32'h0000_1021, 32'h0000_FFFF, 32'h0000_0000);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b1);
        send_item(8'h12, 1'b1, 1'b1, 1'b0);
        drain();
        configure(WIDTH_32, 1'b1, 1'b0, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(8'h34, 1'b1, 1'b0, 1'b1);
        drain();

        // width code with no crc
        configure(WIDTH_NONE, 1'b1, 1'b1, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(8'h55, 1'b1, 1'b1, 1'b1);
        drain();

        // random phases under random configurations
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = (phase_no >= 4 && phase_no < 7);
            case ($urandom_range(9))
                0, 1, 2: wm = WIDTH_8;
                3, 4, 5: wm = WIDTH_16;
                9:       wm = WIDTH_NONE;
                default: wm = WIDTH_32;
            endcase
            configure(wm, 1'($urandom), 1'($urandom), pick_word(), pick_word(), pick_word());
            if ($urandom_range(3) == 0)
            begin
                write_reg(3'($urandom_range(6, 7)), $urandom);
                cfg_we <= 1'b0;
            end
            phase_end = items_sent + $urandom_range(30, 90);
            while (items_sent < phase_end)
            begin
                case ($urandom_range(19))
                    // noise item
                    0: send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                    // broken message: no first or no last
                    1: send_message($urandom_range(1, 6), 1'b0, 1'b1);
                    2: send_message($urandom_range(1, 6), 1'b1, 1'b0);
                    // empty message
                    3: send_message(0, 1'b1, 1'b1);
                    // occasional long message
                    4: send_message($urandom_range(20, 40), 1'b1, 1'b1);
                    default:
                    begin
                        len = $urandom_range(1, 10);
                        send_message(len, 1'b1, 1'b1);
                    end
                endcase
            end
            drain();
            phase_no++;
        end

        no_idle = 1'b0;
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("expected crcs never came out");
        if (sb.errors == 0)
            $display("configurable_crc_engine_core_test: done, clean");
        else
            $display("configurable_crc_engine_core_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cce_pkg.sv
hdl/cce_front.sv
hdl/cce_back.sv
hdl/configurable_crc_engine_core.sv
hdl/cce_checker.sv
verif/configurable_crc_engine_core_test.sv
